// File: hw/rtl/cds_pkg.sv
// types, constants and calendar helper functions for the date step block
`timescale 1ns / 1ps
`default_nettype none

package cds_pkg;

   // field widths
   localparam int CMD_W   = 2;
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 16;
   localparam int DOY_W   = 9;
   localparam int YMOD_W  = 5;

   // command codes
   localparam logic [CMD_W-1:0] CMD_STEP_FWD  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STEP_BACK = 2'd1;
   localparam logic [CMD_W-1:0] CMD_LOAD      = 2'd2;

   // calendar constants
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd0;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd11;
   localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
   localparam logic [DAY_W-1:0]   DAY_DEC_LAST = 5'd31;
   localparam logic [YEAR_W-1:0]  YEAR_MAX = 16'hFFFF;
   localparam logic [YEAR_W-1:0]  YEAR_MIN = 16'h0000;

   // reset date: 1 February 2000 (2000 mod 25 is 0)
   localparam logic [DAY_W-1:0]   RST_DAY   = 5'd1;
   localparam logic [MONTH_W-1:0] RST_MONTH = 4'd1;
   localparam logic [YEAR_W-1:0]  RST_YEAR  = 16'd2000;
   localparam logic [YMOD_W-1:0]  RST_YMOD  = 5'd0;

   // year mod 25 tracking; 65535 mod 25 is 10
   localparam logic [YMOD_W-1:0] YMOD_MAX     = 5'd24;
   localparam logic [YMOD_W-1:0] YMOD_OF_YMAX = 5'd10;

   // reciprocal of 25 scaled by 2**21, exact quotient for any 16-bit year
   localparam int               RECIP_SHIFT = 21;
   localparam logic [16:0]      RECIP_25    = 17'd83887;

   // one input transaction
   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [DAY_W-1:0]   load_day;
      logic [MONTH_W-1:0] load_month;
      logic [YEAR_W-1:0]  load_year;
   } req_type;

   // one result transaction
   typedef struct packed {
      logic [DAY_W-1:0]   cur_day;
      logic [MONTH_W-1:0] cur_month;
      logic [YEAR_W-1:0]  cur_year;
      logic               is_leap;
      logic [DOY_W-1:0]   day_of_year;
      logic               year_wrapped;
   } rsp_type;

   // registered input transaction with the loaded year's remainder mod 25
   typedef struct packed {
      req_type           req;
      logic [YMOD_W-1:0] load_ymod;
   } cmd_pkt_type;

   // held date, with the year's remainder mod 25 carried alongside
   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      logic [YMOD_W-1:0]  ymod;
   } date_type;

   // leap: divisible by 4, and either not by 25 or also by 16
   function automatic logic is_leap_year(input logic [YEAR_W-1:0] year,
                                         input logic [YMOD_W-1:0] ymod);
      return (year[1:0] == 2'b00) && ((ymod != 5'd0) || (year[3:0] == 4'b0000));
   endfunction

   // days in a month
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         4'd1:    len = leap ? 5'd29 : 5'd28;
         4'd3,
         4'd5,
         4'd8,
         4'd10:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   // days in the months before this one, non-leap year
   function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] month);
      logic [DOY_W-1:0] days;
      case (month)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd59;
         4'd3:    days = 9'd90;
         4'd4:    days = 9'd120;
         4'd5:    days = 9'd151;
         4'd6:    days = 9'd181;
         4'd7:    days = 9'd212;
         4'd8:    days = 9'd243;
         4'd9:    days = 9'd273;
         4'd10:   days = 9'd304;
         default: days = 9'd334;   // december; the held month never exceeds it
      endcase
      return days;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cds_in_stage.sv
// input register: captures a transaction and the loaded year's remainder mod 25
`timescale 1ns / 1ps
`default_nettype none

module cds_in_stage (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  cds_pkg::req_type     req_data,
   input  wire                  advance,
   output logic                 s1_valid,
   output cds_pkg::cmd_pkt_type s1_pkt
);

   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   cds_pkg::cmd_pkt_type s1_pkt_ff;
   cds_pkg::cmd_pkt_type s1_pkt_in;
   logic                 accept;
   logic [32:0]          prod;
   logic [11:0]          quot;
   logic [15:0]          quot_x25;

   // quotient by 25 through the scaled reciprocal, then the remainder
   assign prod     = 33'(req_data.load_year) * 33'(cds_pkg::RECIP_25);
   assign quot     = prod[32:cds_pkg::RECIP_SHIFT];
   assign quot_x25 = 16'({quot, 4'b0000}) + 16'({quot, 3'b000}) + 16'(quot);

   always_comb begin
      s1_pkt_in.req       = req_data;
      s1_pkt_in.load_ymod = cds_pkg::YMOD_W'(req_data.load_year - quot_x25);
   end

   // stage holds while the downstream side cannot take it
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pkt_ff <= s1_pkt_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_pkt   = s1_pkt_ff;

endmodule

`default_nettype wire

// File: hw/rtl/cds_date_next.sv
// next-date logic: load, one day forward, one day back, and result fields
`timescale 1ns / 1ps
`default_nettype none

module cds_date_next (
   input  cds_pkg::date_type    cur,
   input  cds_pkg::cmd_pkt_type pkt,
   output cds_pkg::date_type    nxt,
   output cds_pkg::rsp_type     rsp
);

   logic                           leap_cur;
   logic                           leap_nxt;
   logic                           wrapped;
   logic [cds_pkg::DAY_W-1:0]      len_cur;
   logic [cds_pkg::MONTH_W-1:0]    prev_month;
   logic [cds_pkg::MONTH_W-1:0]    load_month;
   logic                           leap_bonus;

   assign leap_cur   = cds_pkg::is_leap_year(cur.year, cur.ymod);
   assign len_cur    = cds_pkg::month_len(cur.month, leap_cur);
   assign prev_month = cur.month - 4'd1;
   assign load_month = (pkt.req.load_month > cds_pkg::MONTH_DEC) ?
                       cds_pkg::MONTH_DEC : pkt.req.load_month;

   // date update per command
   always_comb begin
      nxt     = cur;
      wrapped = 1'b0;
      case (pkt.req.cmd)
         cds_pkg::CMD_LOAD: begin
            nxt.day   = pkt.req.load_day;
            nxt.month = load_month;
            nxt.year  = pkt.req.load_year;
            nxt.ymod  = pkt.load_ymod;
         end
         cds_pkg::CMD_STEP_FWD: begin
            if (cur.day < len_cur) begin
               nxt.day = cur.day + 5'd1;
            end else begin
               nxt.day = cds_pkg::DAY_FIRST;
               if (cur.month >= cds_pkg::MONTH_DEC) begin
                  // new year, with year wrap past the top
                  nxt.month = cds_pkg::MONTH_JAN;
                  nxt.year  = cur.year + 16'd1;
                  if (cur.year == cds_pkg::YEAR_MAX) begin
                     wrapped  = 1'b1;
                     nxt.ymod = 5'd0;
                  end else if (cur.ymod == cds_pkg::YMOD_MAX) begin
                     nxt.ymod = 5'd0;
                  end else begin
                     nxt.ymod = cur.ymod + 5'd1;
                  end
               end else begin
                  nxt.month = cur.month + 4'd1;
               end
            end
         end
         cds_pkg::CMD_STEP_BACK: begin
            if (cur.day > cds_pkg::DAY_FIRST) begin
               nxt.day = cur.day - 5'd1;
            end else if (cur.month == cds_pkg::MONTH_JAN) begin
               // back into december of the previous year
               nxt.month = cds_pkg::MONTH_DEC;
               nxt.day   = cds_pkg::DAY_DEC_LAST;
               nxt.year  = cur.year - 16'd1;
               if (cur.year == cds_pkg::YEAR_MIN) begin
                  wrapped  = 1'b1;
                  nxt.ymod = cds_pkg::YMOD_OF_YMAX;
               end else if (cur.ymod == 5'd0) begin
                  nxt.ymod = cds_pkg::YMOD_MAX;
               end else begin
                  nxt.ymod = cur.ymod - 5'd1;
               end
            end else begin
               // same year, so the current leap flag sets february's length
               nxt.month = prev_month;
               nxt.day   = cds_pkg::month_len(prev_month, leap_cur);
            end
         end
         default: begin
            nxt = cur;
         end
      endcase
   end

   // result fields from the new date
   assign leap_nxt   = cds_pkg::is_leap_year(nxt.year, nxt.ymod);
   assign leap_bonus = leap_nxt && (nxt.month > cds_pkg::MONTH_FEB);

   always_comb begin
      rsp.cur_day      = nxt.day;
      rsp.cur_month    = nxt.month;
      rsp.cur_year     = nxt.year;
      rsp.is_leap      = leap_nxt;
      rsp.day_of_year  = cds_pkg::days_before(nxt.month) + 9'(leap_bonus) + 9'(nxt.day);
      rsp.year_wrapped = wrapped;
   end

endmodule

`default_nettype wire

// File: hw/rtl/calendar_date_step.sv
// top level of the gregorian date step block
`timescale 1ns / 1ps
`default_nettype none

// Holds a Gregorian date (day, zero-based month, 16-bit year) that resets to
// 1 February 2000. Each request transaction loads a date (month clamped to
// December), steps one day forward or one day back; command 3 leaves the date
// alone. Every request yields one response with the new date, its leap flag,
// the day of the year and a flag for a year wrap between 65535 and 0. The path
// is an input register followed by the date state and response register, so a
// response follows its request through both registers, and one request is
// taken every cycle for as long as responses are not stalled. The leap rule
// uses a running year-mod-25 count, set on a load from one 16x17 reciprocal
// multiply in the input stage.
module calendar_date_step (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  cds_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output cds_pkg::rsp_type rsp_data
);

   logic                 s1_valid;
   cds_pkg::cmd_pkt_type s1_pkt;
   logic                 advance;
   cds_pkg::date_type    date_ff;
   cds_pkg::date_type    date_in;
   cds_pkg::rsp_type     rsp_data_ff;
   cds_pkg::rsp_type     rsp_data_in;
   logic                 rsp_valid_ff;

   // stage moves forward when the response register is empty or draining
   assign advance = s1_valid && (!rsp_valid_ff || !rsp_stall);

   cds_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .advance   (advance),
      .s1_valid  (s1_valid),
      .s1_pkt    (s1_pkt)
   );

   cds_date_next u_date_next (
      .cur (date_ff),
      .pkt (s1_pkt),
      .nxt (date_in),
      .rsp (rsp_data_in)
   );

   // date state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         date_ff.day   <= cds_pkg::RST_DAY;
         date_ff.month <= cds_pkg::RST_MONTH;
         date_ff.year  <= cds_pkg::RST_YEAR;
         date_ff.ymod  <= cds_pkg::RST_YMOD;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            date_ff      <= date_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // held month and year remainder stay in range
   assert property (@(posedge clock) disable iff (reset)
      (date_ff.month <= cds_pkg::MONTH_DEC) && (date_ff.ymod <= cds_pkg::YMOD_MAX))
      else $error("date state out of range");

   // a year wrap lands on 1 January 0 or 31 December 65535
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.year_wrapped |->
         ((rsp_data_ff.cur_month == cds_pkg::MONTH_JAN) &&
          (rsp_data_ff.cur_year == cds_pkg::YEAR_MIN)) ||
         ((rsp_data_ff.cur_month == cds_pkg::MONTH_DEC) &&
          (rsp_data_ff.cur_year == cds_pkg::YEAR_MAX)))
      else $error("year wrap to a wrong date");

   // a transaction in the input stage is kept while the response is stalled
   assert property (@(posedge clock) disable iff (reset)
      s1_valid && rsp_valid_ff && rsp_stall |=> s1_valid && $stable(date_ff))
      else $error("input stage lost a transaction under stall");

   // the date changes only when a transaction moves through
   assert property (@(posedge clock) disable iff (reset)
      !$past(advance) && !$past(reset) |-> $stable(date_ff))
      else $error("date changed without a transaction");

endmodule

`default_nettype wire

// File: verif/tb_calendar_date_step.sv
// self-checking testbench for the gregorian date step block
`timescale 1ns / 1ps

module tb_calendar_date_step;

   localparam logic [cds_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS   = 525;
   localparam int HOLD_CYCLES    = 80;
   localparam int DRAIN_CYCLES   = 8;
   localparam int STALL_PERCENT  = 11;
   localparam int WATCHDOG_LIMIT = 2000;

   // one row of the directed table
   typedef struct packed {
      cds_pkg::req_type req;
      bit               typed;
      cds_pkg::rsp_type want;
   } directed_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   cds_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   cds_pkg::rsp_type rsp_data;

   // date held by the predictor
   logic [cds_pkg::DAY_W-1:0]   held_day;
   logic [cds_pkg::MONTH_W-1:0] held_month;
   logic [cds_pkg::YEAR_W-1:0]  held_year;

   cds_pkg::rsp_type expected_dates[$];
   directed_row_type directed_rows[$];
   int               mismatches = 0;
   int               idle_cycles = 0;
   bit               calm = 1'b0;
   bit               hold_request = 1'b0;

   calendar_date_step DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 100 MHz clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // 4/100/400 rule
   function automatic bit gregorian_leap(input logic [cds_pkg::YEAR_W-1:0] y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic logic [cds_pkg::DAY_W-1:0] days_in_month(
         input logic [cds_pkg::MONTH_W-1:0] m,
         input logic [cds_pkg::YEAR_W-1:0] y);
      if (m == cds_pkg::MONTH_FEB) return gregorian_leap(y) ? 5'd29 : 5'd28;
      if (m == 4'd3 || m == 4'd5 || m == 4'd8 || m == 4'd10) return 5'd30;
      return 5'd31;
   endfunction

   // sum of the lengths of the months ahead of m in year y
   function automatic logic [cds_pkg::DOY_W-1:0] days_ahead_of(
         input logic [cds_pkg::MONTH_W-1:0] m,
         input logic [cds_pkg::YEAR_W-1:0] y);
      int sum;
      sum = 0;
      for (int k = 0; k < m; k++) sum += days_in_month(4'(k), y);
      return 9'(sum);
   endfunction

   // apply one command to the held date and return the expected result
   function automatic cds_pkg::rsp_type step_date(input cds_pkg::req_type r);
      cds_pkg::rsp_type res;
      logic             wrapped;
      wrapped = 1'b0;
      case (r.cmd)
         cds_pkg::CMD_LOAD: begin
            held_day   = r.load_day;
            held_month = (r.load_month > cds_pkg::MONTH_DEC) ?
                         cds_pkg::MONTH_DEC : r.load_month;
            held_year  = r.load_year;
         end
         cds_pkg::CMD_STEP_FWD: begin
            if (held_day < days_in_month(held_month, held_year)) begin
               held_day = held_day + 5'd1;
            end else begin
               held_day = cds_pkg::DAY_FIRST;
               if (held_month >= cds_pkg::MONTH_DEC) begin
                  held_month = cds_pkg::MONTH_JAN;
                  wrapped    = (held_year == cds_pkg::YEAR_MAX);
                  held_year  = held_year + 16'd1;
               end else begin
                  held_month = held_month + 4'd1;
               end
            end
         end
         cds_pkg::CMD_STEP_BACK: begin
            if (held_day > cds_pkg::DAY_FIRST) begin
               held_day = held_day - 5'd1;
            end else begin
               if (held_month == cds_pkg::MONTH_JAN) begin
                  held_month = cds_pkg::MONTH_DEC;
                  wrapped    = (held_year == cds_pkg::YEAR_MIN);
                  held_year  = held_year - 16'd1;
               end else begin
                  held_month = held_month - 4'd1;
               end
               held_day = days_in_month(held_month, held_year);
            end
         end
         default: ;
      endcase
      res.cur_day      = held_day;
      res.cur_month    = held_month;
      res.cur_year     = held_year;
      res.is_leap      = gregorian_leap(held_year);
      res.day_of_year  = days_ahead_of(held_month, held_year) + 9'(held_day);
      res.year_wrapped = wrapped;
      return res;
   endfunction

   function automatic directed_row_type row(input logic [cds_pkg::CMD_W-1:0] cmd,
                                            input logic [cds_pkg::DAY_W-1:0] day,
                                            input logic [cds_pkg::MONTH_W-1:0] month,
                                            input logic [cds_pkg::YEAR_W-1:0] year,
                                            input bit typed = 1'b0,
                                            input cds_pkg::rsp_type want = '0);
      directed_row_type d;
      d.req.cmd        = cmd;
      d.req.load_day   = day;
      d.req.load_month = month;
      d.req.load_year  = year;
      d.typed          = typed;
      d.want           = want;
      return d;
   endfunction

   // mostly steps, with loads that favor month ends, year ends and century years
   function automatic cds_pkg::req_type random_request();
      cds_pkg::req_type r;
      int               roll;
      int               pick;
      r.load_day   = 5'($urandom_range(31));
      r.load_month = 4'($urandom_range(15));
      r.load_year  = 16'($urandom);
      roll = $urandom_range(99);
      if (roll < 45)      r.cmd = cds_pkg::CMD_STEP_FWD;
      else if (roll < 72) r.cmd = cds_pkg::CMD_STEP_BACK;
      else if (roll < 95) r.cmd = cds_pkg::CMD_LOAD;
      else                r.cmd = CMD_UNUSED;
      if (r.cmd == cds_pkg::CMD_LOAD) begin
         pick = $urandom_range(7);
         case (pick)
            0: begin
               r.load_day   = cds_pkg::DAY_DEC_LAST;
               r.load_month = cds_pkg::MONTH_DEC;
               r.load_year  = cds_pkg::YEAR_MAX;
            end
            1: begin
               r.load_day   = cds_pkg::DAY_FIRST;
               r.load_month = cds_pkg::MONTH_JAN;
               r.load_year  = cds_pkg::YEAR_MIN;
            end
            2: r.load_year = 16'($urandom_range(655) * 100);
            3: r.load_year = 16'($urandom_range(16383) * 4);
            default: ;
         endcase
         // land near the end of the month so the following steps roll over
         if (pick > 1 && $urandom_range(1) == 1) r.load_day = 5'($urandom_range(31, 26));
      end
      return r;
   endfunction

   // offer one transaction, wait for it to be taken, then predict it
   task automatic send_request(input cds_pkg::req_type r,
                               output cds_pkg::rsp_type predicted);
      while (!calm && $urandom_range(99) < STALL_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = step_date(r);
   endtask

   // stop offering until every expected result is back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_dates.size() != 0);
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endtask

   // result side: random stalls, a calm stretch, and one long hold-off
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < STALL_PERCENT);
         end
      end
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      cds_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_dates.size() == 0) begin
            $error("result transaction with no expectation waiting");
            mismatches++;
         end else begin
            want = expected_dates.pop_front();
            compare_field("cur_day", want.cur_day, rsp_data.cur_day);
            compare_field("cur_month", want.cur_month, rsp_data.cur_month);
            compare_field("cur_year", want.cur_year, rsp_data.cur_year);
            compare_field("is_leap", want.is_leap, rsp_data.is_leap);
            compare_field("day_of_year", want.day_of_year, rsp_data.day_of_year);
            compare_field("year_wrapped", want.year_wrapped, rsp_data.year_wrapped);
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles < WATCHDOG_LIMIT) begin
         idle_cycles <= idle_cycles + 1;
      end else begin
         $display("status: fail");
         $finish;
      end
   end

   // stimulus
   initial begin
      cds_pkg::rsp_type predicted;
      cds_pkg::req_type r;

      held_day   = cds_pkg::RST_DAY;
      held_month = cds_pkg::RST_MONTH;
      held_year  = cds_pkg::RST_YEAR;

      // special dates: reset value, year wrap both ways, clamping,
      // out-of-range days, leap and century februaries
      directed_rows.push_back(row(cds_pkg::CMD_STEP_FWD, 5'd0, 4'd0, 16'd0, 1'b1,
         cds_pkg::rsp_type'{5'd2, cds_pkg::MONTH_FEB, 16'd2000, 1'b1, 9'd33, 1'b0}));
      directed_rows.push_back(row(cds_pkg::CMD_LOAD, cds_pkg::DAY_DEC_LAST,
         cds_pkg::MONTH_DEC, cds_pkg::YEAR_MAX, 1'b1,
         cds_pkg::rsp_type'{5'd31, cds_pkg::MONTH_DEC, cds_pkg::YEAR_MAX,
                            1'b0, 9'd365, 1'b0}));
      directed_rows.push_back(row(cds_pkg::CMD_STEP_FWD, 5'd0, 4'd0, 16'd0, 1'b1,
         cds_pkg::rsp_type'{cds_pkg::DAY_FIRST, cds_pkg::MONTH_JAN, cds_pkg::YEAR_MIN,
                            1'b1, 9'd1, 1'b1}));
      directed_rows.push_back(row(cds_pkg::CMD_STEP_BACK, 5'd0, 4'd0, 16'd0, 1'b1,
         cds_pkg::rsp_type'{5'd31, cds_pkg::MONTH_DEC, cds_pkg::YEAR_MAX,
                            1'b0, 9'd365, 1'b1}));
      directed_rows.push_back(row(cds_pkg::CMD_LOAD, 5'd0, 4'd15, 16'd1900, 1'b1,
         cds_pkg::rsp_type'{5'd0, cds_pkg::MONTH_DEC, 16'd1900, 1'b0, 9'd334, 1'b0}));
      directed_rows.push_back(row(CMD_UNUSED, 5'd31, 4'd15, cds_pkg::YEAR_MAX, 1'b1,
         cds_pkg::rsp_type'{5'd0, cds_pkg::MONTH_DEC, 16'd1900, 1'b0, 9'd334, 1'b0}));
      directed_rows.push_back(row(cds_pkg::CMD_STEP_FWD, 5'd0, 4'd0, 16'd0));
      directed_rows.push_back(row(cds_pkg::CMD_LOAD, 5'd31, cds_pkg::MONTH_FEB, 16'd2024));
      directed_rows.push_back(row(cds_pkg::CMD_STEP_FWD, 5'd0, 4'd0, 16'd0));
      directed_rows.push_back(row(cds_pkg::CMD_STEP_BACK, 5'd0, 4'd0, 16'd0));
      directed_rows.push_back(row(cds_pkg::CMD_LOAD, cds_pkg::DAY_FIRST, 4'd2, 16'd1900));
      directed_rows.push_back(row(cds_pkg::CMD_STEP_BACK, 5'd0, 4'd0, 16'd0));
      directed_rows.push_back(row(cds_pkg::CMD_LOAD, cds_pkg::DAY_FIRST, 4'd2, 16'd2000));
      directed_rows.push_back(row(cds_pkg::CMD_STEP_BACK, 5'd0, 4'd0, 16'd0));
      directed_rows.push_back(row(cds_pkg::CMD_LOAD, 5'd0, cds_pkg::MONTH_JAN,
         cds_pkg::YEAR_MIN, 1'b1,
         cds_pkg::rsp_type'{5'd0, cds_pkg::MONTH_JAN, cds_pkg::YEAR_MIN,
                            1'b1, 9'd0, 1'b0}));
      directed_rows.push_back(row(cds_pkg::CMD_STEP_BACK, 5'd0, 4'd0, 16'd0, 1'b1,
         cds_pkg::rsp_type'{5'd31, cds_pkg::MONTH_DEC, cds_pkg::YEAR_MAX,
                            1'b0, 9'd365, 1'b1}));
      directed_rows.push_back(row(cds_pkg::CMD_LOAD, 5'd31, 4'd3, 16'd2023));
      directed_rows.push_back(row(cds_pkg::CMD_STEP_FWD, 5'd0, 4'd0, 16'd0));
      directed_rows.push_back(row(cds_pkg::CMD_LOAD, 5'd28, cds_pkg::MONTH_FEB, 16'd2100));
      directed_rows.push_back(row(cds_pkg::CMD_STEP_FWD, 5'd0, 4'd0, 16'd0));
      directed_rows.push_back(row(cds_pkg::CMD_LOAD, 5'd31, cds_pkg::MONTH_DEC, 16'd2399));
      directed_rows.push_back(row(cds_pkg::CMD_STEP_FWD, 5'd0, 4'd0, 16'd0));
      directed_rows.push_back(row(cds_pkg::CMD_STEP_BACK, 5'd0, 4'd0, 16'd0));
      directed_rows.push_back(row(cds_pkg::CMD_LOAD, 5'd29, cds_pkg::MONTH_FEB, 16'd1999));
      directed_rows.push_back(row(cds_pkg::CMD_STEP_FWD, 5'd0, 4'd0, 16'd0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed part
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].req, predicted);
         expected_dates.push_back(directed_rows[i].typed ? directed_rows[i].want : predicted);
      end
      wait_for_drain();

      // random part, with a long result hold-off, a calm stretch and a pause
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 200) hold_request = 1'b1;
         if (n == 320) calm = 1'b1;
         if (n == 440) begin
            calm = 1'b0;
            wait_for_drain();
         end
         r = random_request();
         send_request(r, predicted);
         expected_dates.push_back(predicted);
      end

      // let the pipeline empty
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_dates.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/cds_pkg.sv
hw/rtl/cds_in_stage.sv
hw/rtl/cds_date_next.sv
hw/rtl/calendar_date_step.sv
verif/tb_calendar_date_step.sv
